// ===== hw/rtl/crcdf_pkg.sv =====
// Shared codes and constants of the CRC-16 packet deframer.
package crcdf_pkg;

	localparam int TIMEOUT_W = 16;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1000;

	localparam logic [7:0]  FRAME_START = 8'h02;
	localparam logic [7:0]  FRAME_END   = 8'h03;
	localparam logic [7:0]  LONG_START  = 8'h03;
	localparam logic [15:0] CRC_POLY    = 16'h1021;

	// request operation codes
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// result kinds
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_STATUS  = 1'b1;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_CRC     = 3'd1,
		ST_LONG    = 3'd2,
		ST_START   = 3'd3,
		ST_END     = 3'd4,
		ST_TIMEOUT = 3'd5
	} status_t;

endpackage

// ===== hw/rtl/crcdf_crc_byte.sv =====
// CRC-16/XMODEM update over one byte, MSB first.
module crcdf_crc_byte (
	input  logic [15:0] crc_in,
	input  logic [7:0]  data,
	output logic [15:0] crc_out
);
	import crcdf_pkg::*;

	always_comb begin
		logic [15:0] c;
		c = crc_in ^ {data, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		crc_out = c;
	end

endmodule

// ===== hw/rtl/crc16_packet_deframer.sv =====
// Top level of the serial packet deframer with CRC-16/XMODEM check.
//
// Receive-side deframer for frames of the form: start byte 0x02, length L,
// L payload bytes, big-endian CRC-16/XMODEM over the payload, end byte 0x03.
// Each request on the input is either a received byte (operation 0) or one
// time tick (operation 1). Payload bytes are passed out as they arrive
// (kind 0); when a frame ends a single status result follows (kind 1) with
// the declared length. Status: 0 ok, 1 CRC mismatch, 2 long frame (start
// byte 0x03, length 0), 3 invalid start byte (length 0), 4 bad end byte
// (beats a CRC mismatch), 5 timeout. Any non-ok status means the payload
// already delivered must be dropped. Bad start bytes resync immediately.
// The tick counter runs only inside a frame, saturates, and fires status 5
// once it reaches timeout_ticks; writing zero disables the timeout. A new
// limit written mid-frame is used from the next tick on.
// Rate: one request per clock cycle sustained while no result is blocked. A request
// is taken into the input register, where the phase step and the byte-wide CRC
// update are done, and its result (if any) is then registered in the output
// register. The input stalls only when a result must be written while the
// output register is still held.
// Configuration: cfg_we/cfg_wdata write timeout_ticks (reset 1000); write it
// only while no frame is in progress.
module crc16_packet_deframer #(
	parameter int TICK_COUNTER_WIDTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// request channel
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            operation,
	input  logic [7:0]                      rx_byte,
	// result channel
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            kind,
	output logic [7:0]                      payload_byte,
	output logic [2:0]                      status,
	output logic [7:0]                      frame_length,
	// configuration
	input  logic                            cfg_we,
	input  logic [crcdf_pkg::TIMEOUT_W-1:0] cfg_wdata
);
	import crcdf_pkg::*;

	localparam int CMP_W = (TICK_COUNTER_WIDTH > TIMEOUT_W) ? TICK_COUNTER_WIDTH : TIMEOUT_W;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_LEN     = 3'd1,
		PH_PAYLOAD = 3'd2,
		PH_CRC_HI  = 3'd3,
		PH_CRC_LO  = 3'd4,
		PH_END     = 3'd5
	} phase_t;

	// input register
	logic       valid_s1;
	logic       op_s1;
	logic [7:0] byte_s1;

	// frame state
	phase_t                        phase_q, phase_n;
	logic [7:0]                    decl_len_q, decl_len_n;
	logic [7:0]                    left_q, left_n;
	logic [15:0]                   crc_q, crc_n;
	logic [15:0]                   rx_crc_q, rx_crc_n;
	logic [TICK_COUNTER_WIDTH-1:0] elapsed_q, elapsed_n, elapsed_inc;
	logic [TIMEOUT_W-1:0]          timeout_q;

	// output register
	logic       out_valid_q;
	logic       kind_q;
	logic [7:0] payload_q;
	logic [2:0] status_q;
	logic [7:0] len_q;

	// result of the request in the input register
	logic       res_vld;
	logic       res_kind;
	logic [7:0] res_pay;
	status_t    res_st;
	logic [7:0] res_len;

	logic        advance;
	logic [15:0] crc_upd;

	crcdf_crc_byte u_crc (
		.crc_in  (crc_q),
		.data    (byte_s1),
		.crc_out (crc_upd)
	);

	assign elapsed_inc = (&elapsed_q) ? elapsed_q : elapsed_q + TICK_COUNTER_WIDTH'(1);

	always_comb begin
		phase_n    = phase_q;
		decl_len_n = decl_len_q;
		left_n     = left_q;
		crc_n      = crc_q;
		rx_crc_n   = rx_crc_q;
		elapsed_n  = elapsed_q;
		res_vld    = 1'b0;
		res_kind   = KIND_STATUS;
		res_pay    = 8'h00;
		res_st     = ST_OK;
		res_len    = 8'h00;
		if (op_s1 == OP_TICK) begin
			if (phase_q != PH_IDLE) begin
				elapsed_n = elapsed_inc;
				if (timeout_q != '0 && CMP_W'(elapsed_inc) >= CMP_W'(timeout_q)) begin
					phase_n   = PH_IDLE;
					elapsed_n = '0;
					res_vld   = 1'b1;
					res_st    = ST_TIMEOUT;
					res_len   = decl_len_q;
				end
			end
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
					if (byte_s1 == FRAME_START) begin
						phase_n    = PH_LEN;
						decl_len_n = 8'h00;
						left_n     = 8'h00;
						crc_n      = 16'h0000;
						rx_crc_n   = 16'h0000;
						elapsed_n  = '0;
					end else begin
						res_vld = 1'b1;
						res_st  = (byte_s1 == LONG_START) ? ST_LONG : ST_START;
					end
				end
				PH_LEN: begin
					decl_len_n = byte_s1;
					left_n     = byte_s1;
					phase_n    = (byte_s1 == 8'h00) ? PH_CRC_HI : PH_PAYLOAD;
				end
				PH_PAYLOAD: begin
					crc_n    = crc_upd;
					left_n   = left_q - 8'd1;
					if (left_q == 8'd1) begin
						phase_n = PH_CRC_HI;
					end
					res_vld  = 1'b1;
					res_kind = KIND_PAYLOAD;
					res_pay  = byte_s1;
				end
				PH_CRC_HI: begin
					rx_crc_n = {byte_s1, 8'h00};
					phase_n  = PH_CRC_LO;
				end
				PH_CRC_LO: begin
					rx_crc_n = {rx_crc_q[15:8], byte_s1};
					phase_n  = PH_END;
				end
				PH_END: begin
					phase_n   = PH_IDLE;
					elapsed_n = '0;
					res_vld   = 1'b1;
					res_len   = decl_len_q;
					if (byte_s1 != FRAME_END) begin
						res_st = ST_END;
					end else begin
						res_st = (crc_q == rx_crc_q) ? ST_OK : ST_CRC;
					end
				end
				default: begin
					phase_n   = PH_IDLE;
					elapsed_n = '0;
				end
			endcase
		end
	end

	// the request in the input register retires unless its result is blocked
	assign advance  = valid_s1 && (!res_vld || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1   <= operation;
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			timeout_q <= cfg_wdata;
		end
	end

	// frame state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			decl_len_q  <= 8'h00;
			left_q      <= 8'h00;
			crc_q       <= 16'h0000;
			rx_crc_q    <= 16'h0000;
			elapsed_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				phase_q    <= phase_n;
				decl_len_q <= decl_len_n;
				left_q     <= left_n;
				crc_q      <= crc_n;
				rx_crc_q   <= rx_crc_n;
				elapsed_q  <= elapsed_n;
			end
			if (advance && res_vld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_vld) begin
			kind_q    <= res_kind;
			payload_q <= res_pay;
			status_q  <= res_st;
			len_q     <= res_len;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign payload_byte = payload_q;
	assign status       = status_q;
	assign frame_length = len_q;

endmodule

// ===== hw/rtl/crcdf_checker.sv =====
// Port-level checks for the deframer, bound to its top level.
module crcdf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       kind,
	input logic [7:0] payload_byte,
	input logic [2:0] status,
	input logic [7:0] frame_length
);
	import crcdf_pkg::*;

	// held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(payload_byte)
			&& $stable(status) && $stable(frame_length))
		else $error("result changed while stalled");

	a_pay_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_PAYLOAD |-> status == ST_OK && frame_length == 8'h00)
		else $error("payload result carries status fields");

	a_stat_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_STATUS |-> payload_byte == 8'h00)
		else $error("status result carries a payload byte");

	a_stat_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_STATUS |-> status <= ST_TIMEOUT)
		else $error("status code out of range");

	a_resync_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_STATUS && (status == ST_LONG || status == ST_START)
			|-> frame_length == 8'h00)
		else $error("start error with nonzero length");

endmodule

bind crc16_packet_deframer crcdf_checker u_crcdf_checker (.*);
